/* rtl/core/bfr_pkg.sv */
package bfr_pkg;

    localparam int BFR_MAX_LETTERS = 64;
    localparam int BFR_COUNT_WIDTH = 32;

    // Per-mille scale and the quotient width that covers it.
    localparam int PM_SCALE = 1000;
    localparam int PM_QW    = 11;

    localparam logic [1:0] CMD_LETTER = 2'd0;
    localparam logic [1:0] CMD_TEXT   = 2'd1;
    localparam logic [1:0] CMD_FETCH  = 2'd2;

    // Tab, line feed, vertical tab, form feed, carriage return and space.
    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

endpackage

/* rtl/core/bfr_ram.sv */
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bfr_divider.sv */
module bfr_divider #(
    parameter int COUNT_WIDTH = bfr_pkg::BFR_COUNT_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [COUNT_WIDTH-1:0]     count,
    input  logic [COUNT_WIDTH-1:0]     length,
    output logic                       done,
    output logic [bfr_pkg::PM_QW-1:0]  quotient
);

    // Computes floor((count*2000 + length) / (2*length)), one quotient bit a cycle.
    localparam int QW = bfr_pkg::PM_QW;
    localparam int NW = COUNT_WIDTH + 12;
    localparam int STW = $clog2(QW + 1);

    typedef enum logic {D_IDLE, D_RUN} div_state_t;

    div_state_t     state_reg;
    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  dsh_reg;
    logic [QW-1:0]  q_reg;
    logic [STW-1:0] step_reg;
    logic           done_reg;
    logic [NW-1:0]  num;

    assign num = (NW'(count) << 11) - (NW'(count) << 5) - (NW'(count) << 4) + NW'(length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            q_reg     <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= num;
                        dsh_reg   <= NW'(length) << QW;
                        q_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg <= {q_reg[QW-2:0], 1'b0};
                    end
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STW'(QW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/bigram_frequency_ranker.sv */
// Bigram frequency ranker.
// Commands enter on cmd/symbol and are taken as a transaction at a rising edge
// where start is high and busy is low. A letter command adds symbol to the
// alphabet, a text command counts symbol against the previous kept byte, and
// a fetch command reports the next unreported pair by descending count.
// Letter loads and whitespace, as well as cmd 3, finish in the accepting cycle.
// A counted text byte goes through a letter map read, a count read and a
// count write-back, in that order, all through the registered-read memories.
// A fetch scans the whole count memory, one slot a cycle. For a ranked pair
// the block then writes the reported mark, reads both letters and divides
// for the per-mille share, the division giving one quotient bit a cycle
// while the two letter-table reads go on; when nothing is left the result
// follows the scan directly. Busy drops as the result shows.
// Each fetch gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// After reset the block clears all MAX_LETTERS*MAX_LETTERS count slots
// (4096 by default), one slot a cycle, with busy held high.
module bigram_frequency_ranker #(
    parameter int MAX_LETTERS = bfr_pkg::BFR_MAX_LETTERS,
    parameter int COUNT_WIDTH = bfr_pkg::BFR_COUNT_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [7:0] symbol,
    output logic       done,
    output logic [7:0] first_letter,
    output logic [7:0] second_letter,
    output logic [31:0] pair_count,
    output logic [9:0] per_mille,
    output logic       no_more
);

    localparam int LW    = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int SLOTS = MAX_LETTERS * MAX_LETTERS;
    localparam int SW    = $clog2(SLOTS);
    localparam int ZW    = $clog2(MAX_LETTERS + 1);
    localparam int CW    = COUNT_WIDTH;
    localparam int QW    = bfr_pkg::PM_QW;
    localparam logic [CW-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TMAP, S_TUPD, S_SCAN, S_MARK, S_LA, S_LB, S_DIV
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   clr_addr_reg, clr_addr_next;
    logic [ZW-1:0]   size_reg, size_next;
    logic [255:0]    map_valid_reg, map_valid_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [LW-1:0]   prev_reg, prev_next;
    logic            prev_valid_reg, prev_valid_next;
    logic            cur_valid_reg, cur_valid_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [SW-1:0]   iss_addr_reg, iss_addr_next;
    logic [LW-1:0]   iss_a_reg, iss_a_next;
    logic [LW-1:0]   iss_b_reg, iss_b_next;
    logic            iss_on_reg, iss_on_next;
    logic            d_valid_reg, d_valid_next;
    logic [SW-1:0]   d_addr_reg, d_addr_next;
    logic [LW-1:0]   d_a_reg, d_a_next;
    logic [LW-1:0]   d_b_reg, d_b_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   best_cnt_reg, best_cnt_next;
    logic [SW-1:0]   best_addr_reg, best_addr_next;
    logic [LW-1:0]   best_a_reg, best_a_next;
    logic [LW-1:0]   best_b_reg, best_b_next;
    logic [7:0]      first_reg, first_next;
    logic [7:0]      second_reg, second_next;
    logic            done_reg, done_next;
    logic            no_more_reg, no_more_next;
    logic [31:0]     cnt_out_reg, cnt_out_next;
    logic [9:0]      pm_reg, pm_next;

    logic            accept;
    logic            load_ok;

    logic            map_we;
    logic [LW-1:0]   map_rdata;
    logic            alpha_we;
    logic [LW-1:0]   alpha_raddr;
    logic [7:0]      alpha_rdata;
    logic            cnt_we;
    logic [SW-1:0]   cnt_waddr;
    logic [CW:0]     cnt_wdata;
    logic [SW-1:0]   cnt_raddr;
    logic [CW:0]     cnt_rdata;
    logic            rd_mark;
    logic [CW-1:0]   rd_cnt;
    logic [CW-1:0]   rd_inc;
    logic [SW-1:0]   slot_calc;
    logic [63:0]     best_ext;

    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_q;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign load_ok = accept && (cmd == bfr_pkg::CMD_LETTER) && !bfr_pkg::is_blank(symbol)
                     && (size_reg < ZW'(MAX_LETTERS));

    assign map_we   = load_ok && !map_valid_reg[symbol];
    assign alpha_we = load_ok;
    assign alpha_raddr = (state_reg == S_MARK) ? best_a_reg : best_b_reg;

    assign rd_mark   = cnt_rdata[CW];
    assign rd_cnt    = cnt_rdata[CW-1:0];
    assign rd_inc    = (rd_cnt == CMAX) ? CMAX : rd_cnt + 1'b1;
    assign slot_calc = SW'(prev_reg) * SW'(MAX_LETTERS) + SW'(map_rdata);
    assign cnt_raddr = (state_reg == S_TMAP) ? slot_calc : iss_addr_reg;
    assign div_start = (state_reg == S_MARK);
    assign best_ext  = 64'(best_cnt_reg);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = clr_addr_reg;
        cnt_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
            end
            S_TUPD:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = slot_reg;
                cnt_wdata = {rd_mark, rd_inc};
            end
            S_MARK:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = best_addr_reg;
                cnt_wdata = {1'b1, best_cnt_reg};
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    bfr_ram #(.WIDTH(LW), .DEPTH(256)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (symbol),
        .wdata (size_reg[LW-1:0]),
        .raddr (symbol),
        .rdata (map_rdata)
    );

    bfr_ram #(.WIDTH(8), .DEPTH(MAX_LETTERS)) u_alpha_ram (
        .clk   (clk),
        .we    (alpha_we),
        .waddr (size_reg[LW-1:0]),
        .wdata (symbol),
        .raddr (alpha_raddr),
        .rdata (alpha_rdata)
    );

    // Each count word carries the reported mark above the saturating count.
    bfr_ram #(.WIDTH(CW + 1), .DEPTH(SLOTS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    bfr_divider #(.COUNT_WIDTH(CW)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (best_cnt_reg),
        .length   (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        size_next       = size_reg;
        map_valid_next  = map_valid_reg;
        len_next        = len_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        cur_valid_next  = cur_valid_reg;
        slot_next       = slot_reg;
        iss_addr_next   = iss_addr_reg;
        iss_a_next      = iss_a_reg;
        iss_b_next      = iss_b_reg;
        iss_on_next     = iss_on_reg;
        d_valid_next    = 1'b0;
        d_addr_next     = iss_addr_reg;
        d_a_next        = iss_a_reg;
        d_b_next        = iss_b_reg;
        found_next      = found_reg;
        best_cnt_next   = best_cnt_reg;
        best_addr_next  = best_addr_reg;
        best_a_next     = best_a_reg;
        best_b_next     = best_b_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        done_next       = 1'b0;
        no_more_next    = no_more_reg;
        cnt_out_next    = cnt_out_reg;
        pm_next         = pm_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (load_ok)
                begin
                    size_next = size_reg + 1'b1;
                    map_valid_next[symbol] = 1'b1;
                end
                if (accept && (cmd == bfr_pkg::CMD_TEXT) && !bfr_pkg::is_blank(symbol))
                begin
                    len_next       = (len_reg == CMAX) ? CMAX : len_reg + 1'b1;
                    cur_valid_next = map_valid_reg[symbol];
                    state_next     = S_TMAP;
                end
                if (accept && (cmd == bfr_pkg::CMD_FETCH))
                begin
                    iss_addr_next = '0;
                    iss_a_next    = '0;
                    iss_b_next    = '0;
                    iss_on_next   = 1'b1;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_TMAP:
            begin
                // The letter map word for the current byte has just arrived.
                slot_next       = slot_calc;
                prev_next       = map_rdata;
                prev_valid_next = cur_valid_reg;
                if (cur_valid_reg && prev_valid_reg)
                begin
                    state_next = S_TUPD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TUPD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // Reads are issued one slot ahead of the compare on returned data.
                if (iss_on_reg)
                begin
                    d_valid_next  = 1'b1;
                    iss_addr_next = iss_addr_reg + 1'b1;
                    if (iss_b_reg == LW'(MAX_LETTERS - 1))
                    begin
                        iss_b_next = '0;
                        iss_a_next = iss_a_reg + 1'b1;
                    end
                    else
                    begin
                        iss_b_next = iss_b_reg + 1'b1;
                    end
                    if (iss_addr_reg == SW'(SLOTS - 1))
                    begin
                        iss_on_next = 1'b0;
                    end
                end
                if (d_valid_reg && !rd_mark && (rd_cnt != '0)
                    && (!found_reg || (rd_cnt > best_cnt_reg)))
                begin
                    found_next     = 1'b1;
                    best_cnt_next  = rd_cnt;
                    best_addr_next = d_addr_reg;
                    best_a_next    = d_a_reg;
                    best_b_next    = d_b_reg;
                end
                if (!iss_on_reg && !d_valid_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        no_more_next = 1'b1;
                        first_next   = '0;
                        second_next  = '0;
                        cnt_out_next = '0;
                        pm_next      = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_MARK:
            begin
                state_next = S_LA;
            end
            S_LA:
            begin
                // The first letter was read as the mark went out.
                first_next = alpha_rdata;
                state_next = S_LB;
            end
            S_LB:
            begin
                second_next = alpha_rdata;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    done_next    = 1'b1;
                    no_more_next = 1'b0;
                    cnt_out_next = best_ext[31:0];
                    if (len_reg == '0)
                    begin
                        pm_next = '0;
                    end
                    else if (div_q > QW'(bfr_pkg::PM_SCALE))
                    begin
                        pm_next = 10'(bfr_pkg::PM_SCALE);
                    end
                    else
                    begin
                        pm_next = div_q[9:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            size_reg       <= '0;
            map_valid_reg  <= '0;
            len_reg        <= '0;
            prev_valid_reg <= 1'b0;
            iss_on_reg     <= 1'b0;
            d_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
            no_more_reg    <= 1'b0;
            first_reg      <= '0;
            second_reg     <= '0;
            cnt_out_reg    <= '0;
            pm_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            size_reg       <= size_next;
            map_valid_reg  <= map_valid_next;
            len_reg        <= len_next;
            prev_valid_reg <= prev_valid_next;
            iss_on_reg     <= iss_on_next;
            d_valid_reg    <= d_valid_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
            no_more_reg    <= no_more_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            cnt_out_reg    <= cnt_out_next;
            pm_reg         <= pm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        cur_valid_reg <= cur_valid_next;
        slot_reg      <= slot_next;
        iss_addr_reg  <= iss_addr_next;
        iss_a_reg     <= iss_a_next;
        iss_b_reg     <= iss_b_next;
        d_addr_reg    <= d_addr_next;
        d_a_reg       <= d_a_next;
        d_b_reg       <= d_b_next;
        best_cnt_reg  <= best_cnt_next;
        best_addr_reg <= best_addr_next;
        best_a_reg    <= best_a_next;
        best_b_reg    <= best_b_next;
    end

    assign done          = done_reg;
    assign first_letter  = first_reg;
    assign second_letter = second_reg;
    assign pair_count    = cnt_out_reg;
    assign per_mille     = pm_reg;
    assign no_more       = no_more_reg;

    // A result is only ever shown as the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("result strobe while busy");

    // An accepted fetch always keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == bfr_pkg::CMD_FETCH)) |=> busy)
        else $error("fetch did not start a scan");

    // An empty report carries a zero count and a zero per-mille share.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && no_more_reg) |-> ((pair_count == '0) && (per_mille == '0)))
        else $error("empty report with nonzero fields");

    // A ranked report has a nonzero count and a share no larger than the whole.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !no_more_reg) |-> ((best_cnt_reg != '0) && (pm_reg <= 10'd1000)))
        else $error("bad ranked report");

endmodule

/* bench/bigram_frequency_ranker_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the ranker, predicts the ranked pairs and
// compares each result with the oldest prediction.
module bigram_frequency_ranker_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  symbol,
    input  logic        done,
    input  logic [7:0]  first_letter,
    input  logic [7:0]  second_letter,
    input  logic [31:0] pair_count,
    input  logic [9:0]  per_mille,
    input  logic        no_more,
    output int          errors,
    output int          pending,
    output int          ranked_seen,
    output int          empty_seen
);

    localparam int LETTERS = bfr_pkg::BFR_MAX_LETTERS;
    localparam int SLOTS = LETTERS * LETTERS;
    localparam longint CNT_MAX = (longint'(1) << bfr_pkg::BFR_COUNT_WIDTH) - 1;

    typedef struct packed {
        logic [7:0]  first;
        logic [7:0]  second;
        logic [31:0] count;
        logic [9:0]  pm;
        logic        last;
    } ranking_t;

    int       pos_of [256];   // 0 when absent, else position + 1
    bit [7:0] alpha [LETTERS];
    int       alpha_len;
    longint   tally [SLOTS];
    bit       shown [SLOTS];
    int       prev_pos;
    longint   kept_len;
    ranking_t ranking_q [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit blank(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Picks the largest unreported count, lowest slot first on ties.
    function automatic ranking_t next_ranking();
        ranking_t r;
        int       best;
        longint   pm;
        best = -1;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!shown[s] && tally[s] != 0 && (best < 0 || tally[s] > tally[best]))
                best = s;
        end
        r = '0;
        if (best < 0)
        begin
            r.last = 1'b1;
            return r;
        end
        shown[best] = 1'b1;
        pm = 0;
        if (kept_len != 0)
        begin
            pm = (tally[best] * 2000 + kept_len) / (2 * kept_len);
            if (pm > 1000)
                pm = 1000;
        end
        r.first  = alpha[best / LETTERS];
        r.second = alpha[best % LETTERS];
        r.count  = 32'(tally[best]);
        r.pm     = 10'(pm);
        return r;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        ranked_seen = 0;
        empty_seen = 0;
        alpha_len = 0;
        prev_pos = 0;
        kept_len = 0;
        foreach (pos_of[i])
            pos_of[i] = 0;
        foreach (tally[i])
            tally[i] = 0;
        foreach (shown[i])
            shown[i] = 0;
    end

    always @(posedge clk)
    begin
        ranking_t got;
        ranking_t want;
        int       cur;
        int       s;
        if (rst_n && start && !busy)
        begin
            if (cmd == bfr_pkg::CMD_LETTER)
            begin
                if (!blank(symbol) && alpha_len < LETTERS)
                begin
                    alpha[alpha_len] = symbol;
                    if (pos_of[symbol] == 0)
                        pos_of[symbol] = alpha_len + 1;
                    alpha_len++;
                end
            end
            else if (cmd == bfr_pkg::CMD_TEXT)
            begin
                if (!blank(symbol))
                begin
                    if (kept_len < CNT_MAX)
                        kept_len++;
                    cur = pos_of[symbol];
                    if (cur != 0 && prev_pos != 0)
                    begin
                        s = (prev_pos - 1) * LETTERS + cur - 1;
                        if (tally[s] < CNT_MAX)
                            tally[s]++;
                    end
                    prev_pos = cur;
                end
            end
            else if (cmd == bfr_pkg::CMD_FETCH)
            begin
                ranking_q = {ranking_q, next_ranking()};
            end
        end
        if (rst_n && done)
        begin
            got = '{first_letter, second_letter, pair_count, per_mille, no_more};
            if (ranking_q.size() == 0)
            begin
                report("unexpected result, pair_count", pair_count, 0);
            end
            else
            begin
                want = ranking_q.pop_front();
                if (got.last !== want.last)     report("no_more", got.last, want.last);
                if (got.first !== want.first)   report("first_letter", got.first, want.first);
                if (got.second !== want.second) report("second_letter", got.second, want.second);
                if (got.count !== want.count)   report("pair_count", got.count, want.count);
                if (got.pm !== want.pm)         report("per_mille", got.pm, want.pm);
                if (want.last)
                    empty_seen++;
                else
                    ranked_seen++;
            end
        end
        pending = ranking_q.size();
    end

endmodule

/* bench/bigram_frequency_ranker_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the bigram frequency ranker. The checker beside
// the block does all prediction; this module only feeds commands.
module bigram_frequency_ranker_tb;

    // The fourth command code has no meaning and must be ignored.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    // Fetches scan the whole count table, all 4096 slots in turn;
    // the limit covers a run made of nothing but fetches several times over.
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic        done;
    logic [7:0]  first_letter;
    logic [7:0]  second_letter;
    logic [31:0] pair_count;
    logic [9:0]  per_mille;
    logic        no_more;

    int     errors, pending, ranked_seen, empty_seen;
    longint cycles;
    int     sent;
    bit     steady;           // no idle gaps while set
    bit [7:0] known_letters [$];

    bigram_frequency_ranker uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .symbol(symbol), .done(done),
        .first_letter(first_letter), .second_letter(second_letter),
        .pair_count(pair_count), .per_mille(per_mille), .no_more(no_more)
    );

    bigram_frequency_ranker_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .symbol(symbol), .done(done),
        .first_letter(first_letter), .second_letter(second_letter),
        .pair_count(pair_count), .per_mille(per_mille), .no_more(no_more),
        .errors(errors), .pending(pending),
        .ranked_seen(ranked_seen), .empty_seen(empty_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("bigram_frequency_ranker test failed");
            $finish;
        end
    end

    // Offers one transaction and returns at the edge that accepts it.
    // Busy only moves on rising edges, so it is read at the falling edge
    // before, which keeps the decision free of races.
    task automatic issue(input logic [1:0] c, input logic [7:0] s);
        while (!steady && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= c;
        symbol <= s;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        sent++;
        if (c == bfr_pkg::CMD_LETTER)
            known_letters = {known_letters, s};
    endtask

    // Draws a text byte: mostly known letters so pairs build up, with some
    // arbitrary bytes and whitespace mixed in.
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 65 && known_letters.size() > 0)
            return known_letters[$urandom_range(known_letters.size() - 1)];
        if (r < 80)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return 8'd9;
            1: return 8'd10;
            2: return 8'd11;
            3: return 8'd12;
            4: return 8'd13;
            default: return 8'd32;
        endcase
    endfunction

    initial
    begin
        int r;
        cycles = 0;
        sent = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = bfr_pkg::CMD_LETTER;
        symbol = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: an empty fetch, extreme bytes, a duplicated letter,
        // whitespace letters and text, a byte outside the alphabet and the
        // unused command code.
        issue(bfr_pkg::CMD_FETCH, 8'd0);
        issue(bfr_pkg::CMD_LETTER, 8'h00);
        issue(bfr_pkg::CMD_LETTER, 8'hFF);
        issue(bfr_pkg::CMD_LETTER, 8'h61);
        issue(bfr_pkg::CMD_LETTER, 8'h00);
        issue(bfr_pkg::CMD_LETTER, 8'd32);
        issue(bfr_pkg::CMD_LETTER, 8'd9);
        issue(bfr_pkg::CMD_TEXT, 8'h00);
        issue(bfr_pkg::CMD_TEXT, 8'hFF);
        issue(bfr_pkg::CMD_TEXT, 8'd13);
        issue(bfr_pkg::CMD_TEXT, 8'h00);
        issue(bfr_pkg::CMD_TEXT, 8'h61);
        issue(bfr_pkg::CMD_TEXT, 8'h7A);
        issue(bfr_pkg::CMD_TEXT, 8'hFF);
        issue(bfr_pkg::CMD_TEXT, 8'h00);
        issue(CMD_UNUSED, 8'hAA);
        issue(CMD_UNUSED, 8'h55);
        issue(bfr_pkg::CMD_FETCH, 8'hFF);
        issue(bfr_pkg::CMD_FETCH, 8'd0);
        issue(bfr_pkg::CMD_FETCH, 8'd0);
        // A reported pair counted again must not come back.
        issue(bfr_pkg::CMD_TEXT, 8'hFF);
        issue(bfr_pkg::CMD_TEXT, 8'h00);
        issue(bfr_pkg::CMD_FETCH, 8'd0);
        issue(bfr_pkg::CMD_FETCH, 8'd0);

        // Random part. Letter loads keep arriving among the text, so the
        // alphabet fills to its capacity and later loads are turned away.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 400 && i < 700);
            r = $urandom_range(99);
            if (r < 11)
                issue(bfr_pkg::CMD_LETTER, 8'($urandom_range(255)));
            else if (r < 90)
                issue(bfr_pkg::CMD_TEXT, text_byte());
            else if (r < 98)
                issue(bfr_pkg::CMD_FETCH, 8'($urandom_range(255)));
            else
                issue(CMD_UNUSED, 8'($urandom_range(255)));
        end
        // Drain the ranking so the exhausted case shows up late as well.
        repeat (6) issue(bfr_pkg::CMD_FETCH, 8'd0);
        start <= 1'b0;

        // Wait for the last transaction to finish and its result to be checked.
        @(negedge clk);
        while (busy || pending != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d commands; checked %0d ranked pairs and %0d empty fetches.",
                 sent, ranked_seen, empty_seen);
        if (errors == 0 && pending == 0)
            $display("bigram_frequency_ranker test passed");
        else
            $display("bigram_frequency_ranker test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bfr_pkg.sv
rtl/core/bfr_ram.sv
rtl/core/bfr_divider.sv
rtl/core/bigram_frequency_ranker.sv
bench/bigram_frequency_ranker_checker.sv
bench/bigram_frequency_ranker_tb.sv
